/* rtl/ghash_pkg.sv */
package ghash_pkg;

  // Command codes carried on the input channel.
  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_AAD    = 2'd1,
    CMD_TEXT   = 2'd2,
    CMD_FINISH = 2'd3
  } cmd_t;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SUBKEY_HIGH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUBKEY_LOW  = 1'b1;

  // Largest number of bytes in one block.
  localparam logic [4:0] BLOCK_BYTES = 5'd16;

  // One result entry of the output buffer.
  typedef struct packed {
    logic [63:0] hash_high;
    logic [63:0] hash_low;
    logic        done_res;
  } result_t;

  // Product of two field elements in GF(2^128) with the GCM bit order:
  // the most significant bit of the vector is the coefficient of x^0.
  // A carry-less product is formed first, then folded twice by
  // x^128 = x^7 + x^2 + x + 1.
  function automatic logic [127:0] gf128_mul(input logic [127:0] x,
                                             input logic [127:0] h);
    logic [127:0] a;
    logic [127:0] b;
    logic [254:0] c;
    logic [126:0] hi;
    logic [133:0] t;
    logic [5:0]   g;
    logic [127:0] r;
    logic [127:0] res;
    // Reverse into polynomial degree order.
    for (int i = 0; i < 128; i++) begin
      a[i] = x[127-i];
      b[i] = h[127-i];
    end
    // Carry-less product, one XOR tree per output coefficient.
    c = '0;
    for (int i = 0; i < 128; i++) begin
      for (int j = 0; j < 128; j++) begin
        c[i+j] = c[i+j] ^ (a[i] & b[j]);
      end
    end
    // First fold of the upper coefficients.
    hi = c[254:128];
    t = {6'b0, c[127:0]} ^ {7'b0, hi} ^ {6'b0, hi, 1'b0} ^
        {5'b0, hi, 2'b0} ^ {hi, 7'b0};
    // Second fold of the few coefficients that remain above x^127.
    g = t[133:128];
    r = t[127:0] ^ {122'b0, g} ^ {121'b0, g, 1'b0} ^
        {120'b0, g, 2'b0} ^ {115'b0, g, 7'b0};
    // Back to GCM bit order.
    for (int i = 0; i < 128; i++) begin
      res[i] = r[127-i];
    end
    return res;
  endfunction

endpackage

/* rtl/ghash_accumulator.sv */
// GHASH accumulator: one GF(2^128) multiply-accumulate per nonempty block or finish.
// An accepted request is loaded into the input stage; when that stage moves forward,
// its result goes to the output register, or to the skid entry if that is stalled.
// Throughput: one request per cycle while the skid entry is empty; the whole
// multiply and reduction is one combinational pass from acc_r back to acc_nxt.
// Reset (rst_n low, synchronous) clears the subkey, accumulator, counters and valids.
module ghash_accumulator (
  input  logic                            clk,
  input  logic                            rst_n,
  // Configuration write channel.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ghash_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                     cfg_data,
  // Input channel.
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_command,
  input  logic [63:0]                     in_block_high,
  input  logic [63:0]                     in_block_low,
  input  logic [4:0]                      in_byte_count,
  // Result channel.
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [63:0]                     out_hash_high,
  output logic [63:0]                     out_hash_low,
  output logic                            out_done_res
);

  // Configuration and state registers.
  logic [63:0] subkey_high_r, subkey_high_nxt;
  logic [63:0] subkey_low_r, subkey_low_nxt;
  logic [127:0] acc_r, acc_nxt;
  logic [63:0] aad_cnt_r, aad_cnt_nxt;
  logic [63:0] text_cnt_r, text_cnt_nxt;

  // Input stage.
  logic                  s1_valid_r, s1_valid_nxt;
  ghash_pkg::cmd_t       s1_cmd_r, s1_cmd_nxt;
  logic [127:0]          s1_block_r, s1_block_nxt;
  logic [4:0]            s1_bytes_r, s1_bytes_nxt;

  // Output register and skid entry.
  logic                  out_valid_r, out_valid_nxt;
  ghash_pkg::result_t    out_data_r, out_data_nxt;
  logic                  skid_valid_r, skid_valid_nxt;
  ghash_pkg::result_t    skid_data_r, skid_data_nxt;

  logic                  in_acc;
  logic                  adv;
  logic                  out_pop;
  logic [4:0]            bytes_sat;
  logic [127:0]          byte_mask;
  logic [127:0]          operand;
  logic                  do_absorb;
  logic [127:0]          product;
  logic [63:0]           bit_add;
  ghash_pkg::result_t    result;

  // Handshake control.
  assign cfg_ready = 1'b1;
  assign in_stall  = s1_valid_r & skid_valid_r;
  assign in_acc    = in_valid & ~in_stall;
  assign adv       = s1_valid_r & ~skid_valid_r;
  assign out_pop   = out_valid_r & ~out_stall;

  // Configuration writes.
  always_comb begin
    subkey_high_nxt = subkey_high_r;
    subkey_low_nxt  = subkey_low_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ghash_pkg::CFG_SUBKEY_HIGH: subkey_high_nxt = cfg_data;
        ghash_pkg::CFG_SUBKEY_LOW:  subkey_low_nxt  = cfg_data;
        default: ;
      endcase
    end
  end

  // Saturate the byte count and zero the bytes beyond it.
  always_comb begin
    bytes_sat = (in_byte_count > ghash_pkg::BLOCK_BYTES) ? ghash_pkg::BLOCK_BYTES
                                                         : in_byte_count;
    for (int i = 0; i < 16; i++) begin
      byte_mask[127-8*i -: 8] = (5'(i) < bytes_sat) ? 8'hff : 8'h00;
    end
  end

  // Input stage capture.
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_cmd_nxt   = s1_cmd_r;
    s1_block_nxt = s1_block_r;
    s1_bytes_nxt = s1_bytes_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
      s1_cmd_nxt   = ghash_pkg::cmd_t'(in_command);
      s1_block_nxt = {in_block_high, in_block_low} & byte_mask;
      s1_bytes_nxt = bytes_sat;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // Multiply-accumulate datapath.
  assign operand   = (s1_cmd_r == ghash_pkg::CMD_FINISH) ? {aad_cnt_r, text_cnt_r}
                                                         : s1_block_r;
  assign product   = ghash_pkg::gf128_mul(acc_r ^ operand, {subkey_high_r, subkey_low_r});
  assign bit_add   = {56'b0, s1_bytes_r, 3'b000};

  always_comb begin
    acc_nxt      = acc_r;
    aad_cnt_nxt  = aad_cnt_r;
    text_cnt_nxt = text_cnt_r;
    do_absorb    = 1'b0;
    case (s1_cmd_r)
      ghash_pkg::CMD_START: begin
        acc_nxt      = '0;
        aad_cnt_nxt  = '0;
        text_cnt_nxt = '0;
      end
      ghash_pkg::CMD_AAD: begin
        do_absorb   = (s1_bytes_r != 5'd0);
        aad_cnt_nxt = aad_cnt_r + bit_add;
      end
      ghash_pkg::CMD_TEXT: begin
        do_absorb    = (s1_bytes_r != 5'd0);
        text_cnt_nxt = text_cnt_r + bit_add;
      end
      ghash_pkg::CMD_FINISH: begin
        do_absorb = 1'b1;
      end
      default: ;
    endcase
    if (do_absorb) begin
      acc_nxt = product;
    end
    // Nothing changes unless the input stage moves forward.
    if (!adv) begin
      acc_nxt      = acc_r;
      aad_cnt_nxt  = aad_cnt_r;
      text_cnt_nxt = text_cnt_r;
    end
  end

  // Result for the item leaving the input stage.
  always_comb begin
    result.hash_high = acc_nxt[127:64];
    result.hash_low  = acc_nxt[63:0];
    result.done_res  = (s1_cmd_r == ghash_pkg::CMD_FINISH);
  end

  // Output register with a skid entry behind it.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (out_pop) begin
      if (skid_valid_r) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
    if (adv) begin
      if (!out_valid_r || out_pop) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = result;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = result;
      end
    end
  end

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      subkey_high_r <= '0;
      subkey_low_r  <= '0;
      acc_r         <= '0;
      aad_cnt_r     <= '0;
      text_cnt_r    <= '0;
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      skid_valid_r  <= 1'b0;
    end else begin
      subkey_high_r <= subkey_high_nxt;
      subkey_low_r  <= subkey_low_nxt;
      acc_r         <= acc_nxt;
      aad_cnt_r     <= aad_cnt_nxt;
      text_cnt_r    <= text_cnt_nxt;
      s1_valid_r    <= s1_valid_nxt;
      out_valid_r   <= out_valid_nxt;
      skid_valid_r  <= skid_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    s1_cmd_r    <= s1_cmd_nxt;
    s1_block_r  <= s1_block_nxt;
    s1_bytes_r  <= s1_bytes_nxt;
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  // Result ports.
  assign out_valid     = out_valid_r;
  assign out_hash_high = out_data_r.hash_high;
  assign out_hash_low  = out_data_r.hash_low;
  assign out_done_res  = out_data_r.done_res;

endmodule

/* test/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // One request on the input channel.
  typedef struct {
    ghash_pkg::cmd_t command;
    logic [63:0]     block_high;
    logic [63:0]     block_low;
    logic [4:0]      byte_count;
  } ghash_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [ghash_pkg::CFG_IDX_W-1:0] cfg_index = ghash_pkg::CFG_SUBKEY_HIGH;
  logic [63:0]                     cfg_data = 64'd0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_command = ghash_pkg::CMD_START;
  logic [63:0] in_block_high = 64'd0;
  logic [63:0] in_block_low = 64'd0;
  logic [4:0]  in_byte_count = 5'd0;

  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_hash_high;
  logic [63:0] out_hash_low;
  logic        out_done_res;

  ghash_accumulator DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_block_high (in_block_high),
    .in_block_low  (in_block_low),
    .in_byte_count (in_byte_count),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_hash_high (out_hash_high),
    .out_hash_low  (out_hash_low),
    .out_done_res  (out_done_res)
  );

  always #10 clk = ~clk;

  // Shadow state of the hash engine.
  logic [127:0] subkey = '0;
  logic [127:0] hash_acc = '0;
  logic [63:0]  aad_bits = '0;
  logic [63:0]  text_bits = '0;

  ghash_req_t         pending_reqs[$];
  ghash_pkg::result_t hash_expect[$];

  int errors = 0;
  int queued = 0;
  int in_taken = 0;
  int results_seen = 0;
  int finals_seen = 0;
  int settings_used = 0;
  int holds_done = 0;
  int send_idle_pct = 20;
  int stall_pct = 20;
  logic quiet = 1'b0;
  logic rx_hold = 1'b0;
  int tx_gap = 0;
  int rx_gap = 0;

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  // Product in GF(2^128), GCM bit order: the MSB is the coefficient of x^0.
  function automatic logic [127:0] gf_mult_h(input logic [127:0] x,
                                             input logic [127:0] h);
    logic [127:0] z;
    logic [127:0] v;
    z = '0;
    v = h;
    for (int k = 0; k < 128; k++) begin
      if (x[127-k]) z = z ^ v;
      if (v[0]) v = (v >> 1) ^ {8'he1, 120'd0};
      else v = v >> 1;
    end
    return z;
  endfunction

  // Applies one accepted request to the shadow state and records the hash it yields.
  task automatic ghash_update(input ghash_pkg::cmd_t cmd, input logic [63:0] bh,
                              input logic [63:0] bl, input logic [4:0] count);
    logic [4:0]         n;
    logic [127:0]       mask;
    ghash_pkg::result_t r;
    n = (count > 5'd16) ? 5'd16 : count;
    r.done_res = 1'b0;
    if (cmd == ghash_pkg::CMD_START) begin
      hash_acc = '0;
      aad_bits = '0;
      text_bits = '0;
    end else if (cmd == ghash_pkg::CMD_FINISH) begin
      hash_acc = gf_mult_h(hash_acc ^ {aad_bits, text_bits}, subkey);
      r.done_res = 1'b1;
    end else if (n != 5'd0) begin
      // Bytes past the count are zero.
      mask = {128{1'b1}} << (8 * (16 - n));
      hash_acc = gf_mult_h(hash_acc ^ ({bh, bl} & mask), subkey);
      if (cmd == ghash_pkg::CMD_AAD) aad_bits = aad_bits + 64'(n) * 64'd8;
      else text_bits = text_bits + 64'(n) * 64'd8;
    end
    r.hash_high = hash_acc[127:64];
    r.hash_low = hash_acc[63:0];
    hash_expect.push_back(r);
  endtask

  task automatic push_req(input ghash_pkg::cmd_t cmd, input logic [63:0] bh,
                          input logic [63:0] bl, input logic [4:0] count);
    ghash_req_t q;
    q.command = cmd;
    q.block_high = bh;
    q.block_low = bl;
    q.byte_count = count;
    pending_reqs.push_back(q);
    queued++;
  endtask

  // A well-formed message: start, AAD blocks, text blocks, finish, at times a second finish.
  // Only the last block of each section may be short.
  task automatic queue_message();
    int n_aad;
    int n_text;
    n_aad = $urandom_range(0, 3);
    n_text = $urandom_range(0, 5);
    push_req(ghash_pkg::CMD_START, rnd64(), rnd64(), 5'($urandom_range(0, 31)));
    for (int i = 0; i < n_aad; i++) begin
      push_req(ghash_pkg::CMD_AAD, rnd64(), rnd64(),
               (i == n_aad - 1 && $urandom_range(0, 1)) ?
               5'($urandom_range(1, 16)) : 5'd16);
    end
    for (int i = 0; i < n_text; i++) begin
      push_req(ghash_pkg::CMD_TEXT, rnd64(), rnd64(),
               (i == n_text - 1 && $urandom_range(0, 1)) ?
               5'($urandom_range(1, 16)) : 5'd16);
    end
    push_req(ghash_pkg::CMD_FINISH, rnd64(), rnd64(), 5'($urandom_range(0, 31)));
    if ($urandom_range(0, 9) == 0) begin
      push_req(ghash_pkg::CMD_FINISH, rnd64(), rnd64(), 5'($urandom_range(0, 31)));
    end
  endtask

  // Writes both subkey words over the configuration channel.
  task automatic write_subkey(input logic [127:0] h);
    cfg_valid <= 1'b1;
    cfg_index <= ghash_pkg::CFG_SUBKEY_HIGH;
    cfg_data <= h[127:64];
    do @(posedge clk); while (!cfg_ready);
    subkey[127:64] = h[127:64];
    cfg_index <= ghash_pkg::CFG_SUBKEY_LOW;
    cfg_data <= h[63:0];
    do @(posedge clk); while (!cfg_ready);
    subkey[63:0] = h[63:0];
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Returns at a rising edge once every request has been answered.
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || in_valid || hash_expect.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Request driver: predicts on acceptance, then presents the next request or idles.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        ghash_update(ghash_pkg::cmd_t'(in_command), in_block_high, in_block_low,
                     in_byte_count);
        in_taken <= in_taken + 1;
      end
      if (!in_valid || !in_stall) begin
        if (tx_gap > 0) begin
          in_valid <= 1'b0;
          tx_gap <= tx_gap - 1;
        end else if (pending_reqs.size() != 0) begin
          if (!quiet && $urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            tx_gap <= $urandom_range(0, 2);
          end else begin
            ghash_req_t q;
            q = pending_reqs.pop_front();
            in_valid <= 1'b1;
            in_command <= q.command;
            in_block_high <= q.block_high;
            in_block_low <= q.block_low;
            in_byte_count <= q.byte_count;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each accepted hash, then picks the next stall value.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (out_done_res) finals_seen++;
        if (hash_expect.size() == 0) begin
          errors++;
          $display("%0t: unexpected result hash=%h_%h done=%b", $time,
                   out_hash_high, out_hash_low, out_done_res);
        end else begin
          ghash_pkg::result_t e;
          e = hash_expect.pop_front();
          if (out_hash_high !== e.hash_high) begin
            errors++;
            $display("%0t: hash_high expected %h actual %h", $time,
                     e.hash_high, out_hash_high);
          end
          if (out_hash_low !== e.hash_low) begin
            errors++;
            $display("%0t: hash_low expected %h actual %h", $time,
                     e.hash_low, out_hash_low);
          end
          if (out_done_res !== e.done_res) begin
            errors++;
            $display("%0t: done_res expected %b actual %b", $time,
                     e.done_res, out_done_res);
          end
        end
      end
      if (rx_hold) begin
        out_stall <= 1'b1;
      end else if (rx_gap > 0) begin
        out_stall <= 1'b1;
        rx_gap <= rx_gap - 1;
      end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
        out_stall <= 1'b1;
        rx_gap <= $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Long receiver hold-off in the middle of a busy stretch so the block backs up.
  initial begin
    wait (in_taken >= 600);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (40) @(posedge clk);
    rx_hold <= 1'b0;
    holds_done++;
  end

  // Main sequence: directed requests, then one phase per subkey setting.
  initial begin
    logic [127:0] h;
    int target;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_subkey({rnd64(), rnd64()});
    @(negedge clk);

    // Field extremes, short blocks, ignored fields and odd command orders.
    push_req(ghash_pkg::CMD_START, '1, '1, 5'd31);
    push_req(ghash_pkg::CMD_AAD, '1, '1, 5'd16);
    push_req(ghash_pkg::CMD_AAD, '1, '1, 5'd1);
    push_req(ghash_pkg::CMD_AAD, '1, '1, 5'd7);
    push_req(ghash_pkg::CMD_AAD, '1, '1, 5'd8);
    push_req(ghash_pkg::CMD_AAD, '1, '1, 5'd9);
    push_req(ghash_pkg::CMD_AAD, '1, '1, 5'd15);
    push_req(ghash_pkg::CMD_TEXT, '0, '0, 5'd16);
    push_req(ghash_pkg::CMD_TEXT, '1, '1, 5'd16);
    push_req(ghash_pkg::CMD_TEXT, '1, '1, 5'd0);
    push_req(ghash_pkg::CMD_AAD, '1, '1, 5'd0);
    push_req(ghash_pkg::CMD_TEXT, rnd64(), rnd64(), 5'd17);
    push_req(ghash_pkg::CMD_TEXT, rnd64(), rnd64(), 5'd31);
    push_req(ghash_pkg::CMD_FINISH, '0, '0, 5'd0);
    push_req(ghash_pkg::CMD_FINISH, '1, '1, 5'd16);
    push_req(ghash_pkg::CMD_START, rnd64(), rnd64(), 5'd0);
    push_req(ghash_pkg::CMD_TEXT, rnd64(), rnd64(), 5'd5);
    push_req(ghash_pkg::CMD_AAD, rnd64(), rnd64(), 5'd3);
    push_req(ghash_pkg::CMD_TEXT, rnd64(), rnd64(), 5'd16);
    push_req(ghash_pkg::CMD_FINISH, rnd64(), rnd64(), 5'd31);
    push_req(ghash_pkg::CMD_START, '0, '0, 5'd16);
    push_req(ghash_pkg::CMD_FINISH, '0, '0, 5'd1);
    wait_drained();

    // Subkey extremes first, then random subkeys with longer runs.
    for (int p = 0; p < 7; p++) begin
      case (p)
        0: h = '0;
        1: h = '1;
        2: h = {1'b1, 127'd0};
        3: h = 128'd1;
        default: h = {rnd64(), rnd64()};
      endcase
      write_subkey(h);
      @(negedge clk);
      target = queued + ((p < 4) ? 100 : 410);
      send_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      if (p == 6) quiet = 1'b1;
      while (queued < target) begin
        if ($urandom_range(0, 4) != 0) begin
          queue_message();
        end else begin
          push_req(ghash_pkg::cmd_t'($urandom_range(0, 3)), rnd64(), rnd64(),
                   5'($urandom_range(0, 31)));
        end
      end
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (hash_expect.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, hash_expect.size());
    end
    $display("Ran %0d requests under %0d subkey settings; %0d hashes checked, %0d final.",
             in_taken, settings_used, results_seen, finals_seen);
    $display("Receiver hold-offs with the sender still busy: %0d.", holds_done);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
